[src/vrlo_pkg.sv]
// ---------------------------------------------------------------------------
// vrlo_pkg
// Shared types, constants and helpers for the voxel ray log-odds update block.
// ---------------------------------------------------------------------------
package vrlo_pkg;

  localparam int XW = 5;
  localparam int YW = 5;
  localparam int ZW = 4;
  localparam int AW = XW + YW + ZW;
  localparam int CELLS = 1 << AW;
  localparam int VW = 16;
  localparam int EW = 8;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_RAY  = 2'd0;
  localparam mode_t MODE_SCAN = 2'd1;
  localparam mode_t MODE_READ = 2'd2;
  localparam mode_t MODE_SKIP = 2'd3;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_HIT   = 2'd0;
  localparam reg_idx_t REG_MISS  = 2'd1;
  localparam reg_idx_t REG_FLOOR = 2'd2;
  localparam reg_idx_t REG_CEIL  = 2'd3;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CLEAR, ST_SETUP, ST_WRD, ST_WCHK, ST_WOUT,
    ST_HRD, ST_HCHK, ST_HOUT, ST_RRD, ST_ROUT
  } state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;
    logic setup;
    logic clr_step;
    logic clr_cells;
    logic rd_walk;
    logic rd_hit;
    logic wr_miss;
    logic wr_hit;
    logic step;
    logic out_load;
    logic out_hit;
    logic out_last;
    logic out_read;
  } cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic clr_done;
    logic walk_done;
    logic marked;
  } sts_t;

  function automatic logic signed [VW-1:0] clamp_add(
    input logic signed [VW-1:0] v, input logic signed [VW-1:0] inc,
    input logic signed [VW-1:0] lo, input logic signed [VW-1:0] hi);
    logic signed [VW:0] s;
    begin
      s = $signed({v[VW-1], v}) + $signed({inc[VW-1], inc});
      if (s < $signed({lo[VW-1], lo})) s = $signed({lo[VW-1], lo});
      if (s > $signed({hi[VW-1], hi})) s = $signed({hi[VW-1], hi});
      return s[VW-1:0];
    end
  endfunction

endpackage

[src/vrlo_ctrl.sv]
// ---------------------------------------------------------------------------
// vrlo_ctrl
// Sequencer for clear, walk read-modify-write, hit update and read.
// ---------------------------------------------------------------------------
module vrlo_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_mode,
  input  logic             out_free,
  input  vrlo_pkg::sts_t   sts,
  output vrlo_pkg::cmd_t   cmd
);
  import vrlo_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        // Cell values and marks are swept to zero once after reset.
        cmd.clr_step  = 1'b1;
        cmd.clr_cells = 1'b1;
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_mode)
            MODE_RAY:  state_nxt = ST_SETUP;
            MODE_SCAN: state_nxt = ST_CLEAR;
            MODE_READ: state_nxt = ST_RRD;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_WRD;
      end
      ST_WRD: begin
        if (sts.walk_done) begin
          state_nxt = ST_HRD;
        end else begin
          cmd.rd_walk = 1'b1;
          state_nxt = ST_WCHK;
        end
      end
      ST_WCHK: begin
        if (sts.marked) begin
          cmd.step = 1'b1;
          state_nxt = ST_WRD;
        end else if (out_free) begin
          cmd.wr_miss  = 1'b1;
          cmd.out_load = 1'b1;
          cmd.step     = 1'b1;
          state_nxt    = ST_WRD;
        end else begin
          state_nxt = ST_WOUT;
        end
      end
      ST_WOUT: begin
        if (out_free) begin
          cmd.wr_miss  = 1'b1;
          cmd.out_load = 1'b1;
          cmd.step     = 1'b1;
          state_nxt    = ST_WRD;
        end
      end
      ST_HRD: begin
        cmd.rd_hit = 1'b1;
        state_nxt  = ST_HCHK;
      end
      ST_HCHK: begin
        state_nxt = ST_HOUT;
      end
      ST_HOUT: begin
        if (out_free) begin
          cmd.wr_hit   = 1'b1;
          cmd.out_load = 1'b1;
          cmd.out_hit  = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_RRD: begin
        cmd.rd_hit = 1'b1;
        state_nxt  = ST_ROUT;
      end
      ST_ROUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          cmd.out_read = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[src/vrlo_datapath.sv]
// ---------------------------------------------------------------------------
// vrlo_datapath
// Bresenham walk registers, cell and mark memories, clamp and output register.
// ---------------------------------------------------------------------------
module vrlo_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  vrlo_pkg::cmd_t                   cmd,
  output vrlo_pkg::sts_t                   sts,
  input  logic [vrlo_pkg::XW-1:0]          sx,
  input  logic [vrlo_pkg::YW-1:0]          sy,
  input  logic [vrlo_pkg::ZW-1:0]          sz,
  input  logic [vrlo_pkg::XW-1:0]          ex,
  input  logic [vrlo_pkg::YW-1:0]          ey,
  input  logic [vrlo_pkg::ZW-1:0]          ez,
  input  logic signed [vrlo_pkg::VW-1:0]   hit_inc,
  input  logic signed [vrlo_pkg::VW-1:0]   miss_inc,
  input  logic signed [vrlo_pkg::VW-1:0]   vfloor,
  input  logic signed [vrlo_pkg::VW-1:0]   vceil,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_free,
  output logic [vrlo_pkg::XW-1:0]          out_cell_x,
  output logic [vrlo_pkg::YW-1:0]          out_cell_y,
  output logic [vrlo_pkg::ZW-1:0]          out_cell_z,
  output logic signed [vrlo_pkg::VW-1:0]   out_cell_value,
  output logic                             out_is_hit,
  output logic                             out_is_occupied,
  output logic                             out_last
);
  import vrlo_pkg::*;

  logic signed [VW-1:0] cell_mem [CELLS];
  logic                 mark_mem [CELLS];

  // Walk position and endpoint, coordinates held as 5-bit lanes.
  logic [4:0] p_r [3];
  logic [4:0] e_r [3];
  logic [4:0] d_r [3];
  logic       s_r [3];
  logic [1:0] a_r, b_r, c_r;
  logic signed [EW-1:0] errb_r, errc_r;
  logic [5:0] rem_r;
  logic [AW:0] clr_r;

  logic signed [VW-1:0] rd_r;
  logic                 mk_r;
  logic [AW-1:0]        addr_r;

  logic [4:0] pe [3];
  logic [4:0] ee [3];
  logic [4:0] dd [3];
  logic [AW-1:0] paddr, eaddr;

  // Dominant axis, ties going to x, then y.
  function automatic logic [1:0] dd0ge(input logic [4:0] d [3]);
    begin
      if (d[0] >= d[1] && d[0] >= d[2]) return 2'd0;
      else if (d[1] >= d[2]) return 2'd1;
      else return 2'd2;
    end
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd[i] = (ee[i] > pe[i]) ? ee[i] - pe[i] : pe[i] - ee[i];
    end
  end

  assign pe[0] = sx;
  assign pe[1] = sy;
  assign pe[2] = {1'b0, sz};
  assign ee[0] = ex;
  assign ee[1] = ey;
  assign ee[2] = {1'b0, ez};
  assign paddr = {p_r[2][ZW-1:0], p_r[1], p_r[0]};
  assign eaddr = {e_r[2][ZW-1:0], e_r[1], e_r[0]};

  assign sts.clr_done  = clr_r[AW];
  assign sts.walk_done = (rem_r == 6'd0);
  assign sts.marked    = mk_r;

  logic signed [VW-1:0] cur, upd;
  assign cur = rd_r;
  assign upd = clamp_add(cur, cmd.wr_hit ? hit_inc : miss_inc, vfloor, vceil);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      if (cmd.load) clr_r <= '0;
      else if (cmd.clr_step) clr_r <= clr_r + 1'b1;
    end
  end

  // Mark memory: cleared one entry per cycle after reset and on a new scan.
  always_ff @(posedge clk) begin
    if (cmd.clr_step && !clr_r[AW]) mark_mem[clr_r[AW-1:0]] <= 1'b0;
    else if (cmd.wr_miss) mark_mem[addr_r] <= 1'b1;
    if (cmd.rd_walk) mk_r <= mark_mem[paddr];
  end

  // Cell memory: cleared one entry per cycle after reset.
  always_ff @(posedge clk) begin
    if (cmd.clr_cells && !clr_r[AW]) cell_mem[clr_r[AW-1:0]] <= '0;
    else if (cmd.wr_miss || cmd.wr_hit) cell_mem[addr_r] <= upd;
    if (cmd.rd_walk) begin
      rd_r   <= cell_mem[paddr];
      addr_r <= paddr;
    end else if (cmd.rd_hit) begin
      rd_r   <= cell_mem[eaddr];
      addr_r <= eaddr;
    end
  end

  // Walk registers.
  logic [4:0] da;
  assign da = d_r[a_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (cmd.setup) begin
      rem_r <= {1'b0, d_r[(dd0ge(d_r))]};
    end else if (cmd.step) begin
      rem_r <= rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        p_r[i] <= pe[i];
        e_r[i] <= ee[i];
        d_r[i] <= dd[i];
        s_r[i] <= ee[i] > pe[i];
      end
    end else if (cmd.setup) begin
      a_r <= dd0ge(d_r);
      unique case (dd0ge(d_r))
        2'd0: begin
          b_r <= 2'd1; c_r <= 2'd2;
          errb_r <= EW'(2 * d_r[1]) - EW'(d_r[0]);
          errc_r <= EW'(2 * d_r[2]) - EW'(d_r[0]);
        end
        2'd1: begin
          b_r <= 2'd0; c_r <= 2'd2;
          errb_r <= EW'(2 * d_r[0]) - EW'(d_r[1]);
          errc_r <= EW'(2 * d_r[2]) - EW'(d_r[1]);
        end
        default: begin
          b_r <= 2'd0; c_r <= 2'd1;
          errb_r <= EW'(2 * d_r[0]) - EW'(d_r[2]);
          errc_r <= EW'(2 * d_r[1]) - EW'(d_r[2]);
        end
      endcase
    end else if (cmd.step) begin
      if (errb_r > 0) begin
        p_r[b_r] <= s_r[b_r] ? p_r[b_r] + 1'b1 : p_r[b_r] - 1'b1;
        errb_r   <= errb_r - EW'(2 * da) + EW'(2 * d_r[b_r]);
      end else begin
        errb_r   <= errb_r + EW'(2 * d_r[b_r]);
      end
      if (errc_r > 0) begin
        p_r[c_r] <= s_r[c_r] ? p_r[c_r] + 1'b1 : p_r[c_r] - 1'b1;
        errc_r   <= errc_r - EW'(2 * da) + EW'(2 * d_r[c_r]);
      end else begin
        errc_r   <= errc_r + EW'(2 * d_r[c_r]);
      end
      p_r[a_r] <= s_r[a_r] ? p_r[a_r] + 1'b1 : p_r[a_r] - 1'b1;
    end
  end

  // Output register.
  assign out_free = !out_valid || out_ready;
  logic load_walk;
  assign load_walk = cmd.out_load && !cmd.out_hit && !cmd.out_read;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cell_x      <= load_walk ? p_r[0] : e_r[0];
      out_cell_y      <= load_walk ? p_r[1] : e_r[1];
      out_cell_z      <= load_walk ? p_r[2][ZW-1:0] : e_r[2][ZW-1:0];
      out_cell_value  <= cmd.out_read ? cur : upd;
      out_is_occupied <= cmd.out_read ? (cur > 0) : (upd > 0);
      out_is_hit      <= cmd.out_hit;
      out_last        <= cmd.out_last;
    end
  end

endmodule

[src/voxel_ray_log_odds_update.sv]
// ---------------------------------------------------------------------------
// voxel_ray_log_odds_update
// Log-odds occupancy update of a 32x32x16 voxel grid along 3D Bresenham rays.
// ---------------------------------------------------------------------------
// After reset the block sweeps its cell and mark stores to zero, one entry per
// cycle, and raises in_ready once the sweep is done. A ray item walks d voxels,
// with d the largest axis distance: each gets a memory read, then a check and,
// unless already marked, a write. Acceptance, setup, the end-of-walk test and
// the hit voxel's read, check and write come around the walk. The single-port
// read-modify-write of the cell store paces the ray, and the walk stalls while
// the output register stays full. A new-scan item sweeps the mark store one
// entry per cycle, and no item is accepted during the sweep. A read item reads
// the end cell, then loads the output register; an ignored item is dropped.
// Results leave through an output register, so a stalled consumer holds the
// walk, the hit write and the read result until the register frees up.
module voxel_ray_log_odds_update (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_mode,
  input  logic [vrlo_pkg::XW-1:0]       in_start_x,
  input  logic [vrlo_pkg::YW-1:0]       in_start_y,
  input  logic [vrlo_pkg::ZW-1:0]       in_start_z,
  input  logic [vrlo_pkg::XW-1:0]       in_end_x,
  input  logic [vrlo_pkg::YW-1:0]       in_end_y,
  input  logic [vrlo_pkg::ZW-1:0]       in_end_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vrlo_pkg::XW-1:0]       out_cell_x,
  output logic [vrlo_pkg::YW-1:0]       out_cell_y,
  output logic [vrlo_pkg::ZW-1:0]       out_cell_z,
  output logic signed [vrlo_pkg::VW-1:0] out_cell_value,
  output logic                          out_is_hit,
  output logic                          out_is_occupied,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [vrlo_pkg::VW-1:0]       cfg_data
);
  import vrlo_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic out_free;

  // Configuration registers, reset to 0.8, -0.4, -2.0 and 3.5 in Q8.8.
  logic signed [VW-1:0] hit_r, miss_r, floor_r, ceil_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= 16'sd205;
      miss_r  <= -16'sd102;
      floor_r <= -16'sd512;
      ceil_r  <= 16'sd896;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HIT:   hit_r   <= cfg_data;
        REG_MISS:  miss_r  <= cfg_data;
        REG_FLOOR: floor_r <= cfg_data;
        REG_CEIL:  ceil_r  <= cfg_data;
        default:   ;
      endcase
    end
  end

  vrlo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_mode),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  vrlo_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .sx              (in_start_x),
    .sy              (in_start_y),
    .sz              (in_start_z),
    .ex              (in_end_x),
    .ey              (in_end_y),
    .ez              (in_end_z),
    .hit_inc         (hit_r),
    .miss_inc        (miss_r),
    .vfloor          (floor_r),
    .vceil           (ceil_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_free        (out_free),
    .out_cell_x      (out_cell_x),
    .out_cell_y      (out_cell_y),
    .out_cell_z      (out_cell_z),
    .out_cell_value  (out_cell_value),
    .out_is_hit      (out_is_hit),
    .out_is_occupied (out_is_occupied),
    .out_last        (out_last)
  );

endmodule
